// ===== rtl/addressable_led_serial_encoder_top_macros.svh =====
// Assertion macros for the addressable LED serial encoder.
// Used by addressable_led_serial_encoder_top; expects clk and arst_n in scope.
`ifndef ADDRESSABLE_LED_SERIAL_ENCODER_TOP_MACROS_SVH
`define ADDRESSABLE_LED_SERIAL_ENCODER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ALSE_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

`define ALSE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ALSE_ASSERT_SAME(label, ante, cons)

`define ALSE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/alse_pkg.sv =====
// Shared types and constants for the addressable LED serial encoder.
// No dependencies.
package alse_pkg;

	localparam int PIXELS         = 64;
	localparam int BITS_PER_PIXEL = 24;
	localparam int PIX_W          = $clog2(PIXELS);
	localparam int BIT_W          = $clog2(BITS_PER_PIXEL);

	localparam logic [7:0] RST_BIT_PERIOD = 8'd20;
	localparam logic [7:0] RST_ONE_HIGH   = 8'd15;
	localparam logic [7:0] RST_ZERO_HIGH  = 8'd6;
	localparam logic [7:0] RST_TAIL       = 8'd45;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_SET   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_START = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_BIT_PERIOD = 2'd0,
		REG_ONE_HIGH   = 2'd1,
		REG_ZERO_HIGH  = 2'd2,
		REG_TAIL       = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_DATA = 2'd1,
		PH_TAIL = 2'd2
	} phase_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [5:0] pixel_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} item_t;

	typedef struct packed {
		logic line_level;
		logic sending;
		logic frame_done;
		logic rejected;
	} result_t;

	typedef struct packed {
		op_t                       op;
		logic                      set_ok;
		logic [PIX_W-1:0]          addr;
		logic [BITS_PER_PIXEL-1:0] word;
	} cmd_t;

endpackage

// ===== rtl/alse_front.sv =====
// Front end: decodes an input beat into a command for the back end.
// Depends on alse_pkg.
module alse_front import alse_pkg::*; (
	input  item_t item,
	output cmd_t  cmd
);

	logic in_range;

	assign in_range = int'(item.pixel_index) < PIXELS;

	always_comb begin
		cmd.op     = op_t'(item.operation);
		cmd.set_ok = (op_t'(item.operation) == OP_SET) && in_range;
		cmd.addr   = PIX_W'(item.pixel_index);
		cmd.word   = BITS_PER_PIXEL'({item.green, item.red, item.blue})
			<< (BITS_PER_PIXEL - 24);
	end

endmodule

// ===== rtl/alse_fifo.sv =====
// Two-entry command queue between front and back end.
// Depends on alse_pkg.
module alse_fifo import alse_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic empty,
	output cmd_t head
);

	cmd_t       buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = count_q == 2'd2;
	assign empty = count_q == 2'd0;
	assign head  = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/alse_back.sv =====
// Back end: colour store, waveform sequencer, config registers, result register.
// Depends on alse_pkg.
module alse_back import alse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  cmd_t       cmd,
	output logic       cmd_pop,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	output logic       res_valid,
	input  logic       res_stall,
	output result_t    res
);

	logic [7:0] bit_period_q;
	logic [7:0] one_high_q;
	logic [7:0] zero_high_q;
	logic [7:0] tail_cfg_q;

	logic [BITS_PER_PIXEL-1:0] mem [PIXELS];
	logic [PIXELS-1:0]         valid_q;
	logic [BITS_PER_PIXEL-1:0] rd_word_q;
	logic                      rd_valid_q;
	logic [BITS_PER_PIXEL-1:0] cur_word_q;
	logic                      fresh_q;

	phase_t           phase_q, phase_d;
	logic [PIX_W-1:0] pix_q, pix_d;
	logic [BIT_W-1:0] bit_q, bit_d;
	logic [7:0]       tick_q, tick_d;
	logic [7:0]       tail_q, tail_d;
	logic             fresh_d;

	result_t res_q, res_d;
	logic    res_valid_q;

	logic                      exec;
	logic                      busy;
	logic [8:0]                tick_sum;
	logic                      period_end;
	logic                      bit_last;
	logic                      pix_last;
	logic [7:0]                tail_sum;
	logic                      tail_end;
	logic [BITS_PER_PIXEL-1:0] fetched;
	logic [BITS_PER_PIXEL-1:0] word;
	logic                      cur_bit;
	logic [7:0]                high;
	logic                      line;

	logic             wr_en;
	logic             rd_en;
	logic [PIX_W-1:0] rd_addr;
	logic             clr;

	assign exec    = cmd_valid && (!res_valid_q || !res_stall);
	assign cmd_pop = exec;
	assign busy    = (phase_q == PH_DATA) || (phase_q == PH_TAIL);

	assign tick_sum   = {1'b0, tick_q} + 9'd1;
	assign period_end = tick_sum >= {1'b0, bit_period_q};
	assign bit_last   = bit_q == BIT_W'(BITS_PER_PIXEL - 1);
	assign pix_last   = pix_q == PIX_W'(PIXELS - 1);
	assign tail_sum   = tail_q + 8'd1;
	assign tail_end   = tail_sum >= tail_cfg_q;
	assign fetched    = rd_valid_q ? rd_word_q : '0;
	assign word       = fresh_q ? fetched : cur_word_q;
	assign cur_bit    = word[BIT_W'(BITS_PER_PIXEL - 1) - bit_q];
	assign high       = cur_bit ? one_high_q : zero_high_q;
	assign line       = tick_q < high;

	// next state
	always_comb begin
		phase_d = phase_q;
		pix_d   = pix_q;
		bit_d   = bit_q;
		tick_d  = tick_q;
		tail_d  = tail_q;
		fresh_d = 1'b0;
		if (exec) begin
			if (cmd.op == OP_TICK) begin
				case (phase_q)
					PH_DATA: begin
						tick_d = period_end ? 8'd0 : tick_sum[7:0];
						if (period_end) begin
							bit_d = bit_q + BIT_W'(1);
							if (bit_last) begin
								bit_d = '0;
								pix_d = pix_q + PIX_W'(1);
								if (pix_last) begin
									pix_d   = '0;
									tail_d  = 8'd0;
									phase_d = (tail_cfg_q == 8'd0) ? PH_IDLE : PH_TAIL;
								end else begin
									fresh_d = 1'b1;
								end
							end
						end
					end
					PH_TAIL: begin
						tick_d = period_end ? 8'd0 : tick_sum[7:0];
						if (period_end) begin
							tail_d = tail_end ? 8'd0 : tail_sum;
							if (tail_end) begin
								phase_d = PH_IDLE;
							end
						end
					end
					default: ;
				endcase
			end else if (!busy && cmd.op == OP_START) begin
				phase_d = PH_DATA;
				pix_d   = '0;
				bit_d   = '0;
				tick_d  = 8'd0;
				tail_d  = 8'd0;
				fresh_d = 1'b1;
			end
		end
	end

	// outputs and store control
	always_comb begin
		res_d   = '0;
		wr_en   = 1'b0;
		clr     = 1'b0;
		rd_en   = fresh_q;
		rd_addr = pix_q + PIX_W'(1);
		if (exec) begin
			if (cmd.op == OP_TICK) begin
				case (phase_q)
					PH_DATA: begin
						res_d.line_level = line;
						res_d.sending    = 1'b1;
						res_d.frame_done = period_end && bit_last && pix_last
							&& (tail_cfg_q == 8'd0);
					end
					PH_TAIL: begin
						res_d.sending    = 1'b1;
						res_d.frame_done = period_end && tail_end;
					end
					default: ;
				endcase
			end else if (busy) begin
				res_d.rejected = 1'b1;
				res_d.sending  = 1'b1;
			end else begin
				case (cmd.op)
					OP_SET:   wr_en = cmd.set_ok;
					OP_CLEAR: clr = 1'b1;
					OP_START: begin
						res_d.sending = 1'b1;
						rd_en         = 1'b1;
						rd_addr       = '0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cmd.addr] <= cmd.word;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (fresh_q) begin
			cur_word_q <= fetched;
		end
		if (exec) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			rd_valid_q   <= 1'b0;
			fresh_q      <= 1'b0;
			phase_q      <= PH_IDLE;
			pix_q        <= '0;
			bit_q        <= '0;
			tick_q       <= 8'd0;
			tail_q       <= 8'd0;
			res_valid_q  <= 1'b0;
			bit_period_q <= RST_BIT_PERIOD;
			one_high_q   <= RST_ONE_HIGH;
			zero_high_q  <= RST_ZERO_HIGH;
			tail_cfg_q   <= RST_TAIL;
		end else begin
			if (clr) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[cmd.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
			fresh_q <= fresh_d;
			phase_q <= phase_d;
			pix_q   <= pix_d;
			bit_q   <= bit_d;
			tick_q  <= tick_d;
			tail_q  <= tail_d;
			if (exec) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_BIT_PERIOD: bit_period_q <= cfg_data;
					REG_ONE_HIGH:   one_high_q   <= cfg_data;
					REG_ZERO_HIGH:  zero_high_q  <= cfg_data;
					REG_TAIL:       tail_cfg_q   <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== rtl/addressable_led_serial_encoder_top.sv =====
// Top level of the addressable LED serial encoder (one-wire RGB LED driver).
// Depends on alse_pkg, alse_front, alse_fifo, alse_back and the assertion macro header.

// Takes one beat per clock when item_stall is low: a PWM base tick or a command
// (set pixel, clear all, start frame), and returns one result beat for each from
// the back end's result register. Beats pass through a two-entry command queue;
// the back end retires one command per cycle while the result side does not stall,
// so the sustained rate is one beat per cycle. The 64 x 24-bit colour store is a
// single-port memory with one registered read; per-entry valid flags make reset and
// clear-all take effect at once, with no sweep. During a frame the next pixel is
// prefetched from the store while the current one is shifted out.
`include "addressable_led_serial_encoder_top_macros.svh"

module addressable_led_serial_encoder_top import alse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  item_t      item,
	output logic       res_valid,
	input  logic       res_stall,
	output result_t    res,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	cmd_t front_cmd;
	cmd_t head_cmd;
	logic q_full;
	logic q_empty;
	logic q_pop;
	logic q_push;

	assign item_stall = q_full;
	assign q_push     = item_valid && !q_full;

	alse_front u_front (
		.item (item),
		.cmd  (front_cmd)
	);

	alse_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (front_cmd),
		.pop      (q_pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (head_cmd)
	);

	alse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!q_empty),
		.cmd       (head_cmd),
		.cmd_pop   (q_pop),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	`ALSE_ASSERT_SAME(a_done_sending, res_valid && res.frame_done, res.sending)
	`ALSE_ASSERT_SAME(a_rej_quiet, res_valid && res.rejected, res.sending && !res.line_level && !res.frame_done)
	`ALSE_ASSERT_SAME(a_line_sending, res_valid && res.line_level, res.sending)
	`ALSE_ASSERT_NEXT(a_pop_fills, q_pop && !res_stall, res_valid)

endmodule

// ===== dv/addressable_led_serial_encoder_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for addressable_led_serial_encoder_top: random pixel, frame and tick
// beats under bursty input and a stalling result side, checked against a waveform predictor.
// Depends on alse_pkg and the encoder RTL only.
module addressable_led_serial_encoder_top_tb;
	import alse_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int MAX_REPORTS = 100;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_LIGHT,
		RX_HEAVY,
		RX_PERIODIC
	} rx_mode_t;

	class led_wave_model;
		logic [BITS_PER_PIXEL-1:0] colours [PIXELS];
		phase_t phase;
		logic [PIX_W-1:0] pix;
		logic [BIT_W-1:0] bitpos;
		logic [7:0] tick, tail_done;
		logic [7:0] period, one_hi, zero_hi, tail_len;
		result_t line_forecast [$];
		int accepted, checked, frames, refusals, errors;

		function new();
			foreach (colours[i]) colours[i] = '0;
			phase = PH_IDLE;
			pix = '0;
			bitpos = '0;
			tick = '0;
			tail_done = '0;
			period = RST_BIT_PERIOD;
			one_hi = RST_ONE_HIGH;
			zero_hi = RST_ZERO_HIGH;
			tail_len = RST_TAIL;
			accepted = 0;
			checked = 0;
			frames = 0;
			refusals = 0;
			errors = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [7:0] v);
			case (idx)
				REG_BIT_PERIOD: period = v;
				REG_ONE_HIGH: one_hi = v;
				REG_ZERO_HIGH: zero_hi = v;
				REG_TAIL: tail_len = v;
				default: ;
			endcase
		endfunction

		function bit busy();
			return phase == PH_DATA || phase == PH_TAIL;
		endfunction

		function bit period_closes();
			tick = tick + 8'd1;
			if (tick >= period) begin
				tick = '0;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_item(item_t it);
			result_t r;
			logic [7:0] hi;
			r = '0;
			accepted++;
			if (op_t'(it.operation) == OP_TICK) begin
				if (phase == PH_DATA) begin
					hi = colours[pix][BITS_PER_PIXEL - 1 - bitpos] ? one_hi : zero_hi;
					r.line_level = tick < hi;
					r.sending = 1'b1;
					if (period_closes()) begin
						if (bitpos != BITS_PER_PIXEL - 1) begin
							bitpos++;
						end else begin
							bitpos = '0;
							if (pix != PIXELS - 1) begin
								pix++;
							end else begin
								pix = '0;
								tail_done = '0;
								if (tail_len == 0) begin
									phase = PH_IDLE;
									r.frame_done = 1'b1;
								end else begin
									phase = PH_TAIL;
								end
							end
						end
					end
				end else if (phase == PH_TAIL) begin
					r.sending = 1'b1;
					if (period_closes()) begin
						tail_done = tail_done + 8'd1;
						if (tail_done >= tail_len) begin
							tail_done = '0;
							phase = PH_IDLE;
							r.frame_done = 1'b1;
						end
					end
				end
			end else if (busy()) begin
				r.rejected = 1'b1;
				r.sending = 1'b1;
				refusals++;
			end else begin
				case (op_t'(it.operation))
					OP_SET: colours[it.pixel_index] = {it.green, it.red, it.blue};
					OP_CLEAR: foreach (colours[i]) colours[i] = '0;
					default: begin
						phase = PH_DATA;
						pix = '0;
						bitpos = '0;
						tick = '0;
						tail_done = '0;
						r.sending = 1'b1;
					end
				endcase
			end
			if (r.frame_done) frames++;
			line_forecast.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (line_forecast.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t ns: unexpected result beat: expected none, got line=%b send=%b done=%b rej=%b",
						$time, got.line_level, got.sending, got.frame_done, got.rejected);
				return;
			end
			want = line_forecast.pop_front();
			checked++;
			if (got !== want) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t ns: beat %0d: expected line=%b send=%b done=%b rej=%b, got line=%b send=%b done=%b rej=%b",
						$time, checked, want.line_level, want.sending, want.frame_done,
						want.rejected, got.line_level, got.sending, got.frame_done, got.rejected);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	result_t res;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_BIT_PERIOD;
	logic [7:0] cfg_data = '0;

	led_wave_model waveform = new();
	int burst_left = 0;
	int quiet_cycles = 0;
	int settings_used = 0;
	rx_mode_t rx_mode = RX_OPEN;
	int rx_run = 0;

	addressable_led_serial_encoder_top uut (
		.clk,
		.arst_n,
		.item_valid,
		.item_stall,
		.item,
		.res_valid,
		.res_stall,
		.res,
		.cfg_we,
		.cfg_index,
		.cfg_data
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (rx_run == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_run = $urandom_range(16, 400);
		end else begin
			rx_run--;
		end
		case (rx_mode)
			RX_OPEN: res_stall <= 1'b0;
			RX_LIGHT: res_stall <= $urandom_range(0, 4) == 0;
			RX_HEAVY: res_stall <= $urandom_range(0, 2) != 0;
			default: res_stall <= (rx_run % 7) < 3;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) waveform.check_result(res);
			if ((item_valid && !item_stall) || (res_valid && !res_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t ns: no beat moved for %0d cycles", $time, QUIET_LIMIT);
				$display("Regression FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// bursts of random length, random gaps between them
	task automatic offer(input item_t it);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400)
				: $urandom_range(1, 24);
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		burst_left--;
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		waveform.note_item(it);
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		burst_left = 0;
		while (waveform.line_forecast.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic put_reg(input reg_idx_t idx, input logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		waveform.set_reg(idx, v);
	endtask

	task automatic program_regs(input logic [7:0] period_ticks, input logic [7:0] one_ticks,
		input logic [7:0] zero_ticks, input logic [7:0] tail_periods);
		put_reg(REG_BIT_PERIOD, period_ticks);
		put_reg(REG_ONE_HIGH, one_ticks);
		put_reg(REG_ZERO_HIGH, zero_ticks);
		put_reg(REG_TAIL, tail_periods);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic item_t cmd_item(input op_t op, input logic [5:0] idx,
		input logic [7:0] g, input logic [7:0] r, input logic [7:0] b);
		item_t it;
		it.operation = op;
		it.pixel_index = idx;
		it.green = g;
		it.red = r;
		it.blue = b;
		return it;
	endfunction

	function automatic logic [7:0] pick_level();
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// mostly ticks while a frame is out; pixel loads and frame starts while idle
	function automatic item_t pick_item(input bit busy);
		item_t it;
		int roll;
		it.pixel_index = 6'($urandom_range(0, PIXELS - 1));
		it.red = pick_level();
		it.green = pick_level();
		it.blue = pick_level();
		roll = $urandom_range(0, 99);
		if (busy)
			it.operation = roll < 96 ? OP_TICK : roll < 97 ? OP_SET : roll < 98 ? OP_CLEAR : OP_START;
		else
			it.operation = roll < 45 ? OP_SET : roll < 48 ? OP_CLEAR : roll < 60 ? OP_START : OP_TICK;
		return it;
	endfunction

	task automatic run_phase(input int min_items, input int min_frames);
		int items_here;
		int frames_at_start;
		items_here = 0;
		frames_at_start = waveform.frames;
		while (items_here < min_items || waveform.frames - frames_at_start < min_frames) begin
			offer(pick_item(waveform.busy()));
			items_here++;
			if ($urandom_range(0, 999) == 0) settle();
		end
	endtask

	initial begin
		item_t tick_beat;
		tick_beat = cmd_item(OP_TICK, 6'd0, 8'h00, 8'h00, 8'h00);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		offer(tick_beat);
		offer(cmd_item(OP_SET, 6'd0, 8'hFF, 8'hFF, 8'hFF));
		offer(cmd_item(OP_SET, 6'd63, 8'hA5, 8'h5A, 8'hC3));
		offer(cmd_item(OP_SET, 6'd1, 8'h00, 8'hFF, 8'h00));
		offer(cmd_item(OP_CLEAR, 6'd0, 8'h00, 8'h00, 8'h00));
		offer(tick_beat);
		offer(cmd_item(OP_SET, 6'd0, 8'hF0, 8'h0F, 8'h81));
		offer(cmd_item(OP_SET, 6'd63, 8'h01, 8'h80, 8'hFF));
		offer(cmd_item(OP_SET, 6'd42, 8'h3C, 8'h00, 8'hAA));
		offer(cmd_item(OP_START, 6'd0, 8'h00, 8'h00, 8'h00));
		offer(cmd_item(OP_SET, 6'd5, 8'h11, 8'h22, 8'h33));
		offer(cmd_item(OP_CLEAR, 6'd0, 8'h00, 8'h00, 8'h00));
		offer(cmd_item(OP_START, 6'd0, 8'h00, 8'h00, 8'h00));
		repeat (12) offer(tick_beat);

		// frame still running: new timing takes effect mid-bit
		settle();
		program_regs(8'd1, 8'd1, 8'd0, 8'd3);
		run_phase(100, 1);
		settle();
		program_regs(8'd0, 8'd255, 8'd1, 8'd0);
		run_phase(40, 0);
		settle();
		program_regs(8'd2, 8'd1, 8'd1, 8'd3);
		run_phase(40, 0);
		settle();
		program_regs(8'd255, 8'd255, 8'd0, 8'd255);
		run_phase(40, 0);
		for (int k = 0; k < 2; k++) begin
			settle();
			program_regs(8'($urandom_range(0, 6)), 8'($urandom_range(0, 8)),
				8'($urandom_range(0, 8)), 8'($urandom_range(0, 6)));
			run_phase(30, 0);
		end
		settle();

		$display("Covered %0d input beats, %0d result beats, %0d register settings;",
			waveform.accepted, waveform.checked, settings_used);
		$display("%0d frames sent to the end of their tail, %0d commands refused while busy.",
			waveform.frames, waveform.refusals);
		if (waveform.errors == 0 && waveform.line_forecast.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
